// ----- hdl/ceq_pkg.sv -----
// ----------------------------------------------------------------------------
// ceq_pkg
// Shared types, codes and limits for the coalescing event queue.
// ----------------------------------------------------------------------------
package ceq_pkg;

	localparam int unsigned DEF_QUEUE_DEPTH = 32;

	localparam logic [8:0]  AMP_MAX = 9'd256;
	localparam logic [20:0] DUR_MIN = 21'd1000;
	localparam logic [20:0] DUR_MAX = 21'd2000000;

	localparam logic [7:0] DEF_VERSION = 8'd1;

	typedef logic [2:0] status_t;

	localparam status_t STAT_QUEUED    = 3'd0;
	localparam status_t STAT_COALESCED = 3'd1;
	localparam status_t STAT_REJECTED  = 3'd2;
	localparam status_t STAT_DROPPED   = 3'd3;
	localparam status_t STAT_EMPTY     = 3'd4;
	localparam status_t STAT_POPPED    = 3'd5;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POLL = 1'b1
	} func_t;

	// one pending request
	typedef struct packed {
		logic        hand;
		logic [7:0]  event_id;
		logic [8:0]  amp;
		logic [20:0] dur;
		logic [22:0] freq;
	} entry_t;

endpackage

// ----- hdl/ceq_cell.sv -----
// ----------------------------------------------------------------------------
// ceq_cell
// One slot of the pending ring: takes its neighbour's entry on a shift, or a
// fresh request on a load.
// ----------------------------------------------------------------------------
module ceq_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load,
	input  ceq_pkg::entry_t shift_in,
	input  ceq_pkg::entry_t load_in,
	output ceq_pkg::entry_t data
);
	import ceq_pkg::*;

	entry_t data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_in;
		end else if (shift) begin
			data_q <= shift_in;
		end
	end

	assign data = data_q;

endmodule

// ----- hdl/coalescing_event_queue.sv -----
// ----------------------------------------------------------------------------
// coalescing_event_queue
// Poll or rejected push: result registered in the cycle after acceptance, one per
// cycle while the output does not stall. Valid push: S_SCAN rotates the cell
// ring past the compare point, then S_FINISH merges, appends or drops; no new
// request is taken until that result is loaded, which waits while the output
// stalls. Reset clears pointers, count, handshake state and sets the accepted
// version to 1; cell contents stay undefined until written.
// ----------------------------------------------------------------------------
module coalescing_event_queue #(
	parameter int unsigned QUEUE_DEPTH = ceq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	// requests in
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [7:0]          version,
	input  logic [7:0]          hand,
	input  logic [7:0]          event_id,
	input  logic signed [15:0]  amplitude,
	input  logic signed [31:0]  duration_us,
	input  logic signed [23:0]  frequency,
	// results out
	output logic                out_valid,
	input  logic                out_stall,
	output ceq_pkg::status_t    status,
	output logic                out_hand,
	output logic [7:0]          out_event,
	output logic [8:0]          out_amplitude,
	output logic [20:0]         out_duration_us,
	output logic [22:0]         out_frequency
);
	import ceq_pkg::*;

	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   scan_q;
	logic            found_q;
	entry_t          new_q;
	logic [7:0]      version_q;

	logic            out_valid_q;
	status_t         status_q;
	entry_t          out_q;

	// ring of cells; cell 0 holds the oldest entry whenever no scan is running
	entry_t          cell_data [QUEUE_DEPTH];
	entry_t          tail_in;
	logic            shift_all;
	logic            load_en;

	// --- front end: check and clamp the incoming request ----------------------
	logic   in_take;
	logic   out_free;
	logic   req_ok;
	entry_t req_entry;

	assign cfg_ready = 1'b1;

	// output register frees up when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_take  = in_valid && !in_stall;

	assign req_ok = (version == version_q) && (hand[7:1] == 7'd0) &&
	                (event_id != 8'd0) && (amplitude > 16'sd0) &&
	                (duration_us > 32'sd0) && !frequency[23];

	always_comb begin
		req_entry          = '0;
		req_entry.hand     = hand[0];
		req_entry.event_id = event_id;
		req_entry.amp      = (amplitude > $signed({7'd0, AMP_MAX})) ? AMP_MAX
		                                                            : amplitude[8:0];
		if (duration_us < $signed({11'd0, DUR_MIN})) begin
			req_entry.dur = DUR_MIN;
		end else if (duration_us > $signed({11'd0, DUR_MAX})) begin
			req_entry.dur = DUR_MAX;
		end else begin
			req_entry.dur = duration_us[20:0];
		end
		req_entry.freq     = frequency[22:0];
	end

	// --- scan: the head passes the compare point once per cycle ---------------
	// Only the first count_q heads are live; the rest are stale slots that
	// rotate round with the ring and must not match.
	logic   head_live;
	logic   head_hit;
	entry_t merged;
	logic   is_full;
	logic   fin_go;
	logic   res_load;

	assign head_live = ({{(CW-IW){1'b0}}, scan_q} < count_q);
	assign head_hit  = head_live && !found_q &&
	                   (cell_data[0].hand == new_q.hand) &&
	                   (cell_data[0].event_id == new_q.event_id);

	always_comb begin
		merged = cell_data[0];
		if (head_hit) begin
			if (new_q.amp > merged.amp) merged.amp = new_q.amp;
			if (new_q.dur > merged.dur) merged.dur = new_q.dur;
			if (new_q.freq != 23'd0)    merged.freq = new_q.freq;
		end
	end

	assign is_full = (count_q == CW'(QUEUE_DEPTH));
	assign fin_go  = (state_q == S_FINISH) && out_free;

	// a result is loaded by a poll, a rejected push or the end of a push
	assign res_load = (in_take && ((func == FUNC_POLL) || !req_ok)) || fin_go;

	// Shift sources: a poll pops the head, the scan rotates the whole ring, and
	// a full append rotates once with the new request entering at the tail,
	// which drops the oldest in the same step.
	assign shift_all = (in_take && (func == FUNC_POLL) && (count_q != '0)) ||
	                   (state_q == S_SCAN) ||
	                   (fin_go && !found_q && is_full);
	assign load_en   = fin_go && !found_q && !is_full;

	always_comb begin
		case (state_q)
			S_SCAN:   tail_in = merged;
			S_FINISH: tail_in = new_q;
			default:  tail_in = cell_data[0];
		endcase
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t nbr;
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nbr = tail_in;
		end else begin : g_body
			assign nbr = cell_data[i+1];
		end
		ceq_cell u_cell (
			.clk      (clk),
			.shift    (shift_all),
			.load     (load_en && (count_q == CW'(i))),
			.shift_in (nbr),
			.load_in  (new_q),
			.data     (cell_data[i])
		);
	end

	// --- control, counters and result register --------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			found_q     <= 1'b0;
			new_q       <= '0;
			version_q   <= DEF_VERSION;
			out_valid_q <= 1'b0;
			status_q    <= STAT_QUEUED;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				version_q <= cfg_data;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (func == FUNC_POLL) begin
							if (count_q == '0) begin
								status_q <= STAT_EMPTY;
								out_q    <= '0;
							end else begin
								status_q <= STAT_POPPED;
								out_q    <= cell_data[0];
								count_q  <= count_q - 1'b1;
							end
						end else if (!req_ok) begin
							status_q <= STAT_REJECTED;
							out_q    <= '0;
						end else begin
							new_q   <= req_entry;
							scan_q  <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (head_hit) begin
						found_q <= 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == IW'(QUEUE_DEPTH - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_q <= '0;
						if (found_q) begin
							status_q <= STAT_COALESCED;
						end else if (is_full) begin
							status_q <= STAT_DROPPED;
						end else begin
							status_q <= STAT_QUEUED;
							count_q  <= count_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign out_hand        = out_q.hand;
	assign out_event       = out_q.event_id;
	assign out_amplitude   = out_q.amp;
	assign out_duration_us = out_q.dur;
	assign out_frequency   = out_q.freq;

	// --- checks ---------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("pending count above depth");

	a_push_scans: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && (func == FUNC_PUSH) && req_ok |=> state_q == S_SCAN)
		else $error("valid push did not start a scan");

	a_scan_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |=> $stable(count_q))
		else $error("count moved during scan");

	a_found_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> $past(state_q) == S_SCAN)
		else $error("match flagged outside scan");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && (state_q == S_SCAN) |-> !head_hit)
		else $error("second merge in one push");

endmodule
